/* hdl/linear_interp_resampler_48k_core_defines.svh */
// Assertion macros shared by the resampler RTL.
// No dependencies; included by the modules that carry checks.
`ifndef LINEAR_INTERP_RESAMPLER_48K_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_48K_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define LIRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lirs: same-cycle check failed");

// Next-cycle implication, off during reset.
`define LIRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lirs: next-cycle check failed");

`endif

/* hdl/lirs_pkg.sv */
// Shared types, constants and helpers for the linear-interpolation resampler.
// No dependencies.
package lirs_pkg;

  localparam int RATE_BITS  = 17;
  localparam int PHASE_BITS = 18;

  localparam logic [PHASE_BITS-1:0] SOURCE_RATE = 18'd48000;
  localparam logic [RATE_BITS-1:0]  RATE_MIN    = 17'd8000;
  localparam logic [RATE_BITS-1:0]  RATE_MAX    = 17'd96000;
  localparam logic [RATE_BITS-1:0]  RATE_RESET  = 17'd48000;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SPAN,   // interpolate held sample against new sample
    FE_TAIL    // end of packet: new sample against itself
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic pass_through;
    logic run_last;
    logic packet_done;
  } job_flags_t;

  typedef struct packed {
    logic run_last;
    logic packet_done;
  } res_flags_t;

  function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [RATE_BITS-1:0] r);
    logic [RATE_BITS-1:0] v;
    if (r < RATE_MIN) begin
      v = RATE_MIN;
    end else if (r > RATE_MAX) begin
      v = RATE_MAX;
    end else begin
      v = r;
    end
    return v;
  endfunction

endpackage

/* hdl/linear_interp_resampler_48k_core.sv */
// Top level of the 48 kHz linear-interpolation resampler: config register,
// front end, job queue, back end and result queue.
// Depends on lirs_pkg, lirs_fifo, lirs_front and lirs_back.

// Takes 48 kHz mono samples, each with a packet-end mark, and produces samples
// at output_rate (clamped to 8000..96000 Hz) by linear interpolation, with the
// output position restarting at zero each packet; the last sample of a packet
// is interpolated with itself. The first sample of a packet gives no output
// unless it also ends the packet. Each input beat yields zero to four result
// beats; run_last flags the last result of an input beat and packet_done the
// last result of a packet (a packet that ends with no result shows none).
// Flow: the front end accepts a beat, then queues its results one at a time
// and closes each run; a beat that only loads the held sample is done once
// accepted. The back end takes an interpolated result through multiply, sum
// and a restoring divider that makes one quotient bit per cycle, and sends an
// end-of-packet pass-through straight to output; the divider sets the
// sustained rate. The job queue lets the front end run ahead of the divider.
// Write cfg_wdata with cfg_we only while the block is idle.
module linear_interp_resampler_48k_core #(
  parameter int SAMPLE_BITS  = 16,
  parameter int JOB_DEPTH    = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // input side
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_BITS-1:0]     source_sample,
  input  logic                              packet_end,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic                              run_last,
  output logic                              packet_done,
  // configuration
  input  logic                              cfg_we,
  input  logic [lirs_pkg::RATE_BITS-1:0]    cfg_wdata
);

  localparam int JOB_W = 2 * SAMPLE_BITS + 2 * lirs_pkg::RATE_BITS
                         + $bits(lirs_pkg::job_flags_t);
  localparam int RES_W = SAMPLE_BITS + $bits(lirs_pkg::res_flags_t);

  logic [lirs_pkg::RATE_BITS-1:0] output_rate;
  logic [lirs_pkg::RATE_BITS-1:0] rate_eff;

  logic             job_push;
  logic             job_full;
  logic [JOB_W-1:0] job_wr;
  logic             job_pop;
  logic             job_empty;
  logic [JOB_W-1:0] job_rd;

  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_wr;
  logic [RES_W-1:0] res_rd;
  lirs_pkg::res_flags_t res_flags;

  // output rate register, saturated before use
  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate <= lirs_pkg::RATE_RESET;
    end else if (cfg_we) begin
      output_rate <= cfg_wdata;
    end
  end

  assign rate_eff = lirs_pkg::clamp_rate(output_rate);

  lirs_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .source_sample (source_sample),
    .packet_end    (packet_end),
    .rate          (rate_eff),
    .job_full      (job_full),
    .job_push      (job_push),
    .job_data      (job_wr)
  );

  lirs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  lirs_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_data  (job_rd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr)
  );

  lirs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign {res_flags, out_sample} = res_rd;
  assign run_last    = res_flags.run_last;
  assign packet_done = res_flags.packet_done;

endmodule

/* hdl/lirs_fifo.sv */
// Small register-based FIFO used for the job queue and the result queue.
// No dependencies.
module lirs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/lirs_front.sv */
// Front end: accepts source beats, tracks phase and held sample, emits jobs.
// Depends on lirs_pkg and the assertion macro header.
`include "linear_interp_resampler_48k_core_defines.svh"

module lirs_front #(
  parameter int SAMPLE_BITS = 16,
  localparam int JOB_W = 2 * SAMPLE_BITS + 2 * lirs_pkg::RATE_BITS
                         + $bits(lirs_pkg::job_flags_t)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [SAMPLE_BITS-1:0]       source_sample,
  input  logic                                packet_end,
  input  logic [lirs_pkg::RATE_BITS-1:0]      rate,
  input  logic                                job_full,
  output logic                                job_push,
  output logic [JOB_W-1:0]                    job_data
);

  lirs_pkg::front_state_t state, state_next;

  logic [SAMPLE_BITS-1:0]            held_sample;
  logic [SAMPLE_BITS-1:0]            cur_sample;
  logic                              held_valid;
  logic                              end_q;
  logic [lirs_pkg::RATE_BITS-1:0]    rate_q;
  logic [lirs_pkg::PHASE_BITS-1:0]   phase;

  logic                              accept;
  logic [lirs_pkg::PHASE_BITS-1:0]   rate_ext;
  logic [lirs_pkg::PHASE_BITS-1:0]   phase_step;
  logic [lirs_pkg::PHASE_BITS-1:0]   phase_wrap;
  logic [lirs_pkg::PHASE_BITS-1:0]   phase_limit;
  logic                              phase_lt;
  logic                              more_here;
  logic                              more_tail;
  logic                              more;
  lirs_pkg::job_flags_t              flags;
  logic [SAMPLE_BITS-1:0]            job_a;

  assign accept      = push && !full;
  assign rate_ext    = {1'b0, rate_q};
  assign phase_lt    = phase < rate_ext;
  assign phase_step  = phase + lirs_pkg::SOURCE_RATE;
  assign phase_wrap  = phase_step - rate_ext;
  assign phase_limit = rate_ext + lirs_pkg::SOURCE_RATE;
  assign more_here   = phase_step < rate_ext;
  // a span result is followed by tail results when the wrapped phase still fits
  assign more_tail   = end_q && (phase_wrap < rate_ext);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lirs_pkg::FE_IDLE: begin
        if (accept) begin
          if (held_valid) begin
            state_next = lirs_pkg::FE_SPAN;
          end else if (packet_end) begin
            state_next = lirs_pkg::FE_TAIL;
          end
        end
      end
      lirs_pkg::FE_SPAN: begin
        if (!phase_lt) begin
          state_next = end_q ? lirs_pkg::FE_TAIL : lirs_pkg::FE_IDLE;
        end
      end
      lirs_pkg::FE_TAIL: begin
        if (!phase_lt) begin
          state_next = lirs_pkg::FE_IDLE;
        end
      end
      default: state_next = lirs_pkg::FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full               = 1'b1;
    job_push           = 1'b0;
    more               = 1'b0;
    job_a              = cur_sample;
    flags.pass_through = 1'b0;
    unique case (state)
      lirs_pkg::FE_IDLE: begin
        full = 1'b0;
      end
      lirs_pkg::FE_SPAN: begin
        job_push = phase_lt && !job_full;
        more     = more_here || more_tail;
        job_a    = held_sample;
      end
      lirs_pkg::FE_TAIL: begin
        job_push           = phase_lt && !job_full;
        more               = more_here;
        flags.pass_through = 1'b1;
      end
      default: full = 1'b1;
    endcase
    flags.run_last    = !more;
    flags.packet_done = !more && end_q;
    job_data = {flags, rate_q, phase[lirs_pkg::RATE_BITS-1:0], job_a, cur_sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lirs_pkg::FE_IDLE;
      held_valid  <= 1'b0;
      phase       <= '0;
      held_sample <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        lirs_pkg::FE_IDLE: begin
          if (accept) begin
            cur_sample <= source_sample;
            end_q      <= packet_end;
            rate_q     <= rate;
            if (!held_valid) begin
              held_valid  <= 1'b1;
              phase       <= '0;
              held_sample <= source_sample;
            end
          end
        end
        lirs_pkg::FE_SPAN: begin
          if (phase_lt) begin
            if (!job_full) begin
              phase <= phase_step;
            end
          end else begin
            phase       <= phase - rate_ext;
            held_sample <= cur_sample;
          end
        end
        lirs_pkg::FE_TAIL: begin
          if (phase_lt) begin
            if (!job_full) begin
              phase <= phase_step;
            end
          end else begin
            held_valid <= 1'b0;
            phase      <= '0;
          end
        end
        default: phase <= '0;
      endcase
    end
  end

  // between beats the phase is always less than one source step
  `LIRS_ASSERT_IMP(a_idle_phase, clk, rst, state == lirs_pkg::FE_IDLE, phase < lirs_pkg::SOURCE_RATE)
  // while emitting, the phase never passes one step beyond the rate
  `LIRS_ASSERT_IMP(a_run_phase, clk, rst, state != lirs_pkg::FE_IDLE, phase < phase_limit)

endmodule

/* hdl/lirs_back.sv */
// Back end: runs interpolation jobs (multiply, sum, serial divide) into results.
// Depends on lirs_pkg and the assertion macro header.
`include "linear_interp_resampler_48k_core_defines.svh"

module lirs_back #(
  parameter int SAMPLE_BITS = 16,
  localparam int JOB_W = 2 * SAMPLE_BITS + 2 * lirs_pkg::RATE_BITS
                         + $bits(lirs_pkg::job_flags_t),
  localparam int RES_W = SAMPLE_BITS + $bits(lirs_pkg::res_flags_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_empty,
  output logic             job_pop,
  input  logic [JOB_W-1:0] job_data,
  input  logic             res_full,
  output logic             res_push,
  output logic [RES_W-1:0] res_data
);

  localparam int PROD_W = SAMPLE_BITS + lirs_pkg::RATE_BITS + 1;
  localparam int MAG_W  = SAMPLE_BITS + lirs_pkg::RATE_BITS - 1;
  localparam int CNT_W  = $clog2(SAMPLE_BITS);

  lirs_pkg::back_state_t state, state_next;

  lirs_pkg::job_flags_t              in_flags;
  logic [lirs_pkg::RATE_BITS-1:0]    in_rate;
  logic [lirs_pkg::RATE_BITS-1:0]    in_pos;
  logic [SAMPLE_BITS-1:0]            in_a;
  logic [SAMPLE_BITS-1:0]            in_b;

  lirs_pkg::job_flags_t              flags;
  logic [lirs_pkg::RATE_BITS-1:0]    rate;
  logic [lirs_pkg::RATE_BITS-1:0]    pos;
  logic signed [SAMPLE_BITS-1:0]     a;
  logic signed [SAMPLE_BITS-1:0]     b;
  logic signed [PROD_W-1:0]          prod_a;
  logic signed [PROD_W-1:0]          prod_b;
  logic                              neg;
  logic [lirs_pkg::RATE_BITS-1:0]    rem;
  logic [SAMPLE_BITS-1:0]            quot;
  logic [CNT_W-1:0]                  cnt;

  logic signed [PROD_W-1:0]          num;
  logic [PROD_W-1:0]                 mag;
  logic [lirs_pkg::RATE_BITS:0]      trial;
  logic                              ge;
  logic [lirs_pkg::RATE_BITS:0]      trial_sub;
  logic                              div_done;
  logic [SAMPLE_BITS-1:0]            value;
  lirs_pkg::res_flags_t              out_flags;

  assign {in_flags, in_rate, in_pos, in_a, in_b} = job_data;

  assign num       = prod_a + prod_b;
  assign mag       = num[PROD_W-1] ? -num : num;
  // restoring divide, one quotient bit per cycle
  assign trial     = {rem, quot[SAMPLE_BITS-1]};
  assign ge        = trial >= {1'b0, rate};
  assign trial_sub = trial - {1'b0, rate};
  assign div_done  = cnt == CNT_W'(SAMPLE_BITS - 1);
  assign value     = neg ? -quot : quot;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lirs_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_next = in_flags.pass_through ? lirs_pkg::BK_OUT : lirs_pkg::BK_MUL;
        end
      end
      lirs_pkg::BK_MUL: state_next = lirs_pkg::BK_SUM;
      lirs_pkg::BK_SUM: state_next = lirs_pkg::BK_DIV;
      lirs_pkg::BK_DIV: begin
        if (div_done) begin
          state_next = lirs_pkg::BK_OUT;
        end
      end
      lirs_pkg::BK_OUT: begin
        if (!res_full) begin
          state_next = lirs_pkg::BK_IDLE;
        end
      end
      default: state_next = lirs_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop  = 1'b0;
    res_push = 1'b0;
    unique case (state)
      lirs_pkg::BK_IDLE: job_pop  = !job_empty;
      lirs_pkg::BK_OUT:  res_push = !res_full;
      default: begin
        job_pop  = 1'b0;
        res_push = 1'b0;
      end
    endcase
    out_flags.run_last    = flags.run_last;
    out_flags.packet_done = flags.packet_done;
    res_data = {out_flags, value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lirs_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lirs_pkg::BK_IDLE: begin
        if (!job_empty) begin
          flags <= in_flags;
          rate  <= in_rate;
          pos   <= in_pos;
          a     <= in_a;
          b     <= in_b;
          // end of packet: sample against itself is the sample
          quot  <= in_a;
          neg   <= 1'b0;
        end
      end
      lirs_pkg::BK_MUL: begin
        prod_a <= a * $signed({1'b0, rate - pos});
        prod_b <= b * $signed({1'b0, pos});
      end
      lirs_pkg::BK_SUM: begin
        neg  <= num[PROD_W-1];
        // quotient fits SAMPLE_BITS, so the upper part is already below rate
        rem  <= {1'b0, mag[MAG_W-1:SAMPLE_BITS]};
        quot <= mag[SAMPLE_BITS-1:0];
        cnt  <= '0;
      end
      lirs_pkg::BK_DIV: begin
        rem  <= ge ? trial_sub[lirs_pkg::RATE_BITS-1:0] : trial[lirs_pkg::RATE_BITS-1:0];
        quot <= {quot[SAMPLE_BITS-2:0], ge};
        cnt  <= cnt + 1'b1;
      end
      default: cnt <= cnt;
    endcase
  end

  // divider remainder stays below the divisor
  `LIRS_ASSERT_IMP(a_rem_bound, clk, rst, state == lirs_pkg::BK_DIV, rem < rate)
  // a pass-through job goes straight to output with a positive sign
  `LIRS_ASSERT_NXT(a_pass_direct, clk, rst, job_pop && in_flags.pass_through, state == lirs_pkg::BK_OUT && !neg)

endmodule

/* dv/linear_interp_resampler_48k_core_tb.sv */
// Self-checking testbench for linear_interp_resampler_48k_core: directed and random
// packets through a bit-true interpolation predictor, randomly paced on both sides.
// Depends on lirs_pkg and the resampler RTL; reads no files.
`timescale 1ns / 100ps

module linear_interp_resampler_48k_core_tb;

  localparam int SW              = 16;
  // Covers front-end work on beats that leave no result.
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic [lirs_pkg::RATE_BITS-1:0]  rate_t;
  typedef logic [lirs_pkg::PHASE_BITS-1:0] phase_t;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 run_last;
    logic                 packet_done;
  } resampled_t;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    push          = 1'b0;
  logic                    full;
  logic signed [SW-1:0]    source_sample = '0;
  logic                    packet_end    = 1'b0;
  logic                    empty;
  logic                    pop           = 1'b0;
  logic signed [SW-1:0]    out_sample;
  logic                    run_last;
  logic                    packet_done;
  logic                    cfg_we        = 1'b0;
  rate_t                   cfg_wdata     = '0;

  // Predictor state, mirrors the block after reset.
  logic signed [SW-1:0]    prev_sample = '0;
  logic                    prev_valid  = 1'b0;
  phase_t                  phase_acc   = '0;
  rate_t                   rate_reg    = lirs_pkg::RATE_RESET;

  resampled_t              resampled_q[$];   // expected result beats, oldest first
  int                      mismatch_count = 0;
  int unsigned             push_gap_max   = 0;
  int unsigned             pop_gap_max    = 0;
  int unsigned             pop_hold_req   = 0;  // long receiver hold-off, taken by the sink
  int unsigned             pop_wait       = 0;
  int unsigned             idle_cycles    = 0;

  always #5 clk = ~clk;

  linear_interp_resampler_48k_core #(
    .SAMPLE_BITS(SW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .source_sample(source_sample),
    .packet_end   (packet_end),
    .empty        (empty),
    .pop          (pop),
    .out_sample   (out_sample),
    .run_last     (run_last),
    .packet_done  (packet_done),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Programmed rate saturated to the supported 8k..96k window.
  function automatic rate_t effective_rate();
    if (rate_reg < lirs_pkg::RATE_MIN) return lirs_pkg::RATE_MIN;
    if (rate_reg > lirs_pkg::RATE_MAX) return lirs_pkg::RATE_MAX;
    return rate_reg;
  endfunction

  // One run of outputs between a and b while the phase is inside this source step.
  // Division truncates toward zero, as SV signed division does.
  function automatic void emit_span(input logic signed [SW-1:0] a,
                                    input logic signed [SW-1:0] b,
                                    input rate_t r, inout int n);
    resampled_t beat;
    longint     num;
    while (phase_acc < r && n < 4) begin
      num = longint'(a) * (longint'(r) - longint'(phase_acc))
          + longint'(b) * longint'(phase_acc);
      beat.sample      = SW'(num / longint'(r));
      beat.run_last    = 1'b0;
      beat.packet_done = 1'b0;
      resampled_q.insert(resampled_q.size(), beat);
      n++;
      phase_acc += lirs_pkg::SOURCE_RATE;
    end
  endfunction

  // Queues the result beats that one accepted input beat causes.
  function automatic void predict_resampled(input logic signed [SW-1:0] s, input logic pend);
    rate_t r;
    int    n;
    int    tail;
    r = effective_rate();
    n = 0;
    if (!prev_valid) begin
      // first sample of a packet only primes the holding register
      prev_valid = 1'b1;
      phase_acc  = '0;
    end else begin
      emit_span(prev_sample, s, r, n);
      phase_acc -= r;
    end
    prev_sample = s;
    if (pend) begin
      // packet tail: the last sample against itself, then restart the position
      emit_span(s, s, r, n);
      prev_valid = 1'b0;
      phase_acc  = '0;
    end
    if (n > 0) begin
      tail = resampled_q.size() - 1;
      resampled_q[tail].run_last    = 1'b1;
      resampled_q[tail].packet_done = pend;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    resampled_t want;
    if (resampled_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat, out_sample %0d", $signed(out_sample)));
      return;
    end
    want = resampled_q.pop_front();
    if (out_sample !== want.sample)
      report_mismatch($sformatf("out_sample got %0d exp %0d",
                                $signed(out_sample), $signed(want.sample)));
    if (run_last !== want.run_last)
      report_mismatch($sformatf("run_last got %b exp %b", run_last, want.run_last));
    if (packet_done !== want.packet_done)
      report_mismatch($sformatf("packet_done got %b exp %b", packet_done, want.packet_done));
  endtask

  // Result sink: checks every accepted beat, then draws the next pop gap.
  // A hold-off request from a test overrides the gap and keeps pop low until it
  // has counted down, so the job and result queues back up into full.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
        pop_wait = $urandom_range(0, pop_gap_max);
      end
      if (pop_hold_req != 0) begin
        pop_wait     = pop_hold_req;
        pop_hold_req = 0;
      end
      if (pop_wait != 0) begin
        pop      <= 1'b0;
        pop_wait = pop_wait - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: any stretch without a beat on either side past the limit is a hang.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, block stopped moving", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one input beat after a random gap; push stays high into the next beat
  // when that one draws no gap, so it is never dropped and raised in one step.
  task automatic send_sample(input logic signed [SW-1:0] s, input logic pend);
    int unsigned gap;
    gap = $urandom_range(0, push_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    source_sample <= s;
    packet_end    <= pend;
    do @(posedge clk); while (full);
    predict_resampled(s, pend);
  endtask

  // Mostly random samples, with full-scale values mixed in.
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(), i == len - 1);
  endtask

  // Waits until every expected beat is out, then lets the front end settle on
  // beats that produce nothing.
  task automatic wait_idle();
    push <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Rate writes only happen with the block idle; packet state is left as is.
  task automatic write_rate(input rate_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rate_reg  = v;
  endtask

  function automatic rate_t pick_rate();
    case ($urandom_range(0, 5))
      0:       return lirs_pkg::RATE_MIN;
      1:       return lirs_pkg::RATE_MAX;
      2:       return rate_t'($urandom);  // anything, out of range too
      default: return rate_t'($urandom_range(8000, 96000));
    endcase
  endfunction

  // Either side idles a random gap between beats, or runs flat out.
  function automatic void set_idling();
    push_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
    pop_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset rate of 48 kHz: full-scale swings, then a one-sample packet.
  task automatic test_default_rate();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
  endtask

  // At 8 kHz the phase runs past the rate, so the closing beat yields nothing
  // and the packet ends without packet_done.
  task automatic test_silent_packet_end();
    write_rate(lirs_pkg::RATE_MIN);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd300, 1'b1);
    send_sample(-16'sd7, 1'b1);
  endtask

  // Out-of-range writes saturate; all-ones and zero exercise every rate bit.
  task automatic test_rate_extremes();
    rate_t rates [6] = '{17'd0, 17'd7999, 17'd96001, 17'h1ffff,
                         lirs_pkg::RATE_MAX, 17'd44100};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
    end
  endtask

  // Phase built up at 44.1k is kept when the rate drops to 8k, so outputs skip.
  task automatic test_mid_packet_rate_change();
    write_rate(17'd44100);
    repeat (4) send_sample(pick_sample(), 1'b0);
    write_rate(lirs_pkg::RATE_MIN);
    send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
  endtask

  // Receiver holds off while the sender keeps pushing at 96k (four results per
  // closing beat), so the queues fill and full backs up the input.
  task automatic test_input_stall();
    write_rate(lirs_pkg::RATE_MAX);
    push_gap_max = 0;
    pop_gap_max  = 16;
    pop_hold_req = HOLD_OFF_CYCLES;
    send_packet(8);
    send_packet(8);
  endtask

  // Random packets over several rates. Lone beats act as noise: with no end
  // mark they leave a packet open across the next rate write.
  task automatic test_random_streams();
    int sent;
    int len;
    for (int seg = 0; seg < 4; seg++) begin
      write_rate(pick_rate());
      sent = 0;
      while (sent < 18) begin
        set_idling();
        if ($urandom_range(0, 7) == 0) begin
          send_sample(pick_sample(), 1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(1, 8);
          send_packet(len);
          sent += len;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_rate();
    test_silent_packet_end();
    test_rate_extremes();
    test_mid_packet_rate_change();
    test_input_stall();
    test_random_streams();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
